/* rtl/perspective_warp_map_generator_core_macros.svh */
// ----------------------------------------------------------------------------
// Perspective warp map generator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_WARP_MAP_GENERATOR_CORE_MACROS_SVH
`define PERSPECTIVE_WARP_MAP_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWMG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWMG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that is also checked during reset.
`define PWMG_ASSERT_NXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/pwmg_pkg.sv */
// ----------------------------------------------------------------------------
// Perspective warp map generator package
// Field widths, register indexes and item types shared by the block.
// ----------------------------------------------------------------------------
package pwmg_pkg;

    localparam int COORD_BITS          = 16;
    localparam int OUT_FRAC_BITS       = 8;
    localparam int OUT_BITS            = COORD_BITS + OUT_FRAC_BITS;
    localparam int COEF_FRAC_BITS_DEF  = 32;
    localparam int NUM_REGS            = 8;
    localparam int REG_IDX_BITS        = $clog2(NUM_REGS);
    localparam int REG_BYTE_SHIFT      = 3;
    localparam int APB_ADDR_BITS       = REG_IDX_BITS + REG_BYTE_SHIFT;
    localparam int APB_DATA_BITS       = 64;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_NUM_X_COEF_X = 3'd0,
        REG_NUM_X_COEF_Y = 3'd1,
        REG_NUM_X_CONST  = 3'd2,
        REG_NUM_Y_COEF_X = 3'd3,
        REG_NUM_Y_COEF_Y = 3'd4,
        REG_NUM_Y_CONST  = 3'd5,
        REG_DEN_COEF_X   = 3'd6,
        REG_DEN_COEF_Y   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_col;
        logic signed [COORD_BITS-1:0] out_row;
    } pix_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] src_col;
        logic signed [OUT_BITS-1:0] src_row;
        logic                       denom_fault;
    } map_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic fault;
    } flags_t;

endpackage

/* rtl/pwmg_div.sv */
// ----------------------------------------------------------------------------
// Perspective warp map divider
// Pipelined restoring division of both numerator magnitudes by the shared
// denominator, one quotient bit per stage, with rounding and saturation.
// ----------------------------------------------------------------------------
module pwmg_div #(
    parameter int COEF_FRAC_BITS = pwmg_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   vld,
    input  logic [pwmg_pkg::COORD_BITS*2+COEF_FRAC_BITS+1:0] mag_x,
    input  logic [pwmg_pkg::COORD_BITS*2+COEF_FRAC_BITS+1:0] mag_y,
    input  logic [pwmg_pkg::COORD_BITS*2+COEF_FRAC_BITS+1:0] den,
    input  pwmg_pkg::flags_t                       flags,
    output logic                                   take,
    output logic                                   map_valid,
    output pwmg_pkg::map_t                         map,
    input  logic                                   map_stall
);

    import pwmg_pkg::*;

    localparam int SW = 2 * COORD_BITS + COEF_FRAC_BITS + 2;
    localparam int RW = SW + 1;
    localparam int QB = OUT_BITS + 1;
    localparam int NS = QB + 2;
    localparam logic [QB-1:0] POS_LIM = QB'((1 << (OUT_BITS - 1)) - 1);
    localparam logic [QB-1:0] NEG_LIM = QB'(1 << (OUT_BITS - 1));
    localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    logic          v_reg   [NS];
    logic          adv     [NS];
    logic [RW-1:0] rem_x_reg [QB+1];
    logic [RW-1:0] rem_y_reg [QB+1];
    logic [QB-1:0] lo_x_reg  [QB+1];
    logic [QB-1:0] lo_y_reg  [QB+1];
    logic [QB-1:0] q_x_reg   [QB+1];
    logic [QB-1:0] q_y_reg   [QB+1];
    logic [SW-1:0] den_reg   [QB+1];
    logic [1:0]    sat_reg   [QB+1];
    flags_t        flg_reg   [QB+1];
    map_t          map_reg;
    map_t          map_next;
    logic [1:0]    sat_next;

    function automatic logic [OUT_BITS-1:0] finish(input logic [QB-1:0] q2,
                                                   input logic sat,
                                                   input logic neg);
        logic [QB:0]   rnd;
        logic [QB-1:0] qr;
        logic [OUT_BITS-1:0] res;
        rnd = {1'b0, q2} + (QB+1)'(1);
        qr  = rnd[QB:1];
        if (!neg) begin
            res = (sat || (qr > POS_LIM)) ? OUT_MAX : qr[OUT_BITS-1:0];
        end else begin
            res = (sat || (qr > NEG_LIM)) ? OUT_MIN : OUT_BITS'(QB'(0) - qr);
        end
        return res;
    endfunction

    assign adv[NS-1] = !v_reg[NS-1] || !map_stall;
    for (genvar s = 0; s < NS - 1; s++) begin : g_adv
        assign adv[s] = !v_reg[s] || adv[s+1];
    end
    assign take = adv[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int s = 0; s < NS; s++) begin
                v_reg[s] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                v_reg[0] <= vld;
            end
            for (int s = 1; s < NS; s++) begin
                if (adv[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_comb
    begin
        sat_next[1] = {{COORD_BITS{1'b0}}, mag_x} >= {den, {COORD_BITS{1'b0}}};
        sat_next[0] = {{COORD_BITS{1'b0}}, mag_y} >= {den, {COORD_BITS{1'b0}}};
    end

    always_ff @(posedge clk) begin
        if (adv[0]) begin
            rem_x_reg[0] <= {{(COORD_BITS+1){1'b0}}, mag_x[SW-1:COORD_BITS]};
            rem_y_reg[0] <= {{(COORD_BITS+1){1'b0}}, mag_y[SW-1:COORD_BITS]};
            lo_x_reg[0]  <= {mag_x[COORD_BITS-1:0], {(OUT_FRAC_BITS+1){1'b0}}};
            lo_y_reg[0]  <= {mag_y[COORD_BITS-1:0], {(OUT_FRAC_BITS+1){1'b0}}};
            q_x_reg[0]   <= '0;
            q_y_reg[0]   <= '0;
            den_reg[0]   <= den;
            sat_reg[0]   <= sat_next;
            flg_reg[0]   <= flags;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [RW-1:0] trial_x;
        logic [RW-1:0] trial_y;
        logic          ge_x;
        logic          ge_y;

        assign trial_x = {rem_x_reg[k-1][RW-2:0], lo_x_reg[k-1][QB-1]};
        assign trial_y = {rem_y_reg[k-1][RW-2:0], lo_y_reg[k-1][QB-1]};
        assign ge_x    = trial_x >= {1'b0, den_reg[k-1]};
        assign ge_y    = trial_y >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk) begin
            if (adv[k]) begin
                rem_x_reg[k] <= ge_x ? (trial_x - {1'b0, den_reg[k-1]}) : trial_x;
                rem_y_reg[k] <= ge_y ? (trial_y - {1'b0, den_reg[k-1]}) : trial_y;
                lo_x_reg[k]  <= lo_x_reg[k-1] << 1;
                lo_y_reg[k]  <= lo_y_reg[k-1] << 1;
                q_x_reg[k]   <= {q_x_reg[k-1][QB-2:0], ge_x};
                q_y_reg[k]   <= {q_y_reg[k-1][QB-2:0], ge_y};
                den_reg[k]   <= den_reg[k-1];
                sat_reg[k]   <= sat_reg[k-1];
                flg_reg[k]   <= flg_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (flg_reg[QB].fault) begin
            map_next.src_col     = OUT_MIN;
            map_next.src_row     = OUT_MIN;
            map_next.denom_fault = 1'b1;
        end else begin
            map_next.src_col     = finish(q_x_reg[QB], sat_reg[QB][1], flg_reg[QB].neg_x);
            map_next.src_row     = finish(q_y_reg[QB], sat_reg[QB][0], flg_reg[QB].neg_y);
            map_next.denom_fault = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (adv[NS-1]) begin
            map_reg <= map_next;
        end
    end

    assign map_valid = v_reg[NS-1];
    assign map       = map_reg;

endmodule

/* rtl/perspective_warp_map_generator_core.sv */
// ----------------------------------------------------------------------------
// Perspective warp map generator core
// Maps each output pixel to its source coordinate through a fixed-point
// inverse homography with rounding, saturation and a denominator fault.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Content
//  pix       in         pix_valid/stall     out_col, out_row
//  map       out        map_valid/stall     src_col, src_row, denom_fault
//  apb       in/out     psel/penable        eight Q16.32 coefficients
//
//  One item enters per cycle unless map_stall backs up a full pipeline; the
//  datapath is three arithmetic stages followed by the one-bit-per-stage divider.
//  Reset clears all stage valid bits and loads the identity coefficients.
//  A stage holds only when it is full and the stage after it is blocked, so
//  a stalled output still lets empty stages fill.
// ----------------------------------------------------------------------------
module perspective_warp_map_generator_core #(
    parameter int COEF_FRAC_BITS = pwmg_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  pwmg_pkg::pix_t                     pix,
    output logic                               map_valid,
    input  logic                               map_stall,
    output pwmg_pkg::map_t                     map,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pwmg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [pwmg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [pwmg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    import pwmg_pkg::*;

    localparam int CB = COORD_BITS + COEF_FRAC_BITS;
    localparam int PW = CB + COORD_BITS;
    localparam int SW = PW + 2;
    localparam logic signed [CB-1:0] COEF_ONE = CB'(1) << COEF_FRAC_BITS;
    localparam logic [SW-1:0] DEN_ONE = SW'(1) << COEF_FRAC_BITS;

    logic signed [CB-1:0] coef_reg [NUM_REGS];
    logic [REG_IDX_BITS-1:0] reg_idx;

    logic signed [PW-1:0] p_reg  [6];
    logic signed [PW-1:0] p_next [6];
    logic [SW-1:0] num_x_reg;
    logic [SW-1:0] num_y_reg;
    logic [SW-1:0] den_b_reg;
    logic [SW-1:0] num_x_next;
    logic [SW-1:0] num_y_next;
    logic [SW-1:0] den_b_next;
    logic [SW-1:0] mag_x_reg;
    logic [SW-1:0] mag_y_reg;
    logic [SW-1:0] den_c_reg;
    flags_t        flg_reg;
    logic [SW-1:0] mag_x_next;
    logic [SW-1:0] mag_y_next;
    flags_t        flg_next;
    logic va_reg;
    logic vb_reg;
    logic vc_reg;
    logic adv_a;
    logic adv_b;
    logic adv_c;
    logic take;

    assign reg_idx = paddr[APB_ADDR_BITS-1:REG_BYTE_SHIFT];
    assign pready  = 1'b1;
    assign prdata  = APB_DATA_BITS'(coef_reg[reg_idx]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                coef_reg[i] <= '0;
            end
            coef_reg[REG_NUM_X_COEF_X] <= COEF_ONE;
            coef_reg[REG_NUM_Y_COEF_Y] <= COEF_ONE;
        end else if (psel && penable && pwrite && pready) begin
            coef_reg[reg_idx] <= pwdata[CB-1:0];
        end
    end

    assign adv_c     = !vc_reg || take;
    assign adv_b     = !vb_reg || adv_c;
    assign adv_a     = !va_reg || adv_b;
    assign pix_stall = !adv_a;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                va_reg <= pix_valid;
            end
            if (adv_b) begin
                vb_reg <= va_reg;
            end
            if (adv_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_comb
    begin
        p_next[0] = coef_reg[REG_NUM_X_COEF_X] * $signed(pix.out_col);
        p_next[1] = coef_reg[REG_NUM_X_COEF_Y] * $signed(pix.out_row);
        p_next[2] = coef_reg[REG_NUM_Y_COEF_X] * $signed(pix.out_col);
        p_next[3] = coef_reg[REG_NUM_Y_COEF_Y] * $signed(pix.out_row);
        p_next[4] = coef_reg[REG_DEN_COEF_X] * $signed(pix.out_col);
        p_next[5] = coef_reg[REG_DEN_COEF_Y] * $signed(pix.out_row);
    end

    always_comb
    begin
        num_x_next = SW'(p_reg[0]) + SW'(p_reg[1]) + SW'(coef_reg[REG_NUM_X_CONST]);
        num_y_next = SW'(p_reg[2]) + SW'(p_reg[3]) + SW'(coef_reg[REG_NUM_Y_CONST]);
        den_b_next = SW'(p_reg[4]) + SW'(p_reg[5]) + DEN_ONE;
    end

    always_comb
    begin
        flg_next.neg_x = num_x_reg[SW-1];
        flg_next.neg_y = num_y_reg[SW-1];
        flg_next.fault = den_b_reg[SW-1] || (den_b_reg == '0);
        mag_x_next     = num_x_reg[SW-1] ? (SW'(0) - num_x_reg) : num_x_reg;
        mag_y_next     = num_y_reg[SW-1] ? (SW'(0) - num_y_reg) : num_y_reg;
    end

    always_ff @(posedge clk) begin
        if (adv_a) begin
            for (int i = 0; i < 6; i++) begin
                p_reg[i] <= p_next[i];
            end
        end
        if (adv_b) begin
            num_x_reg <= num_x_next;
            num_y_reg <= num_y_next;
            den_b_reg <= den_b_next;
        end
        if (adv_c) begin
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            den_c_reg <= den_b_reg;
            flg_reg   <= flg_next;
        end
    end

    pwmg_div #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld       (vc_reg),
        .mag_x     (mag_x_reg),
        .mag_y     (mag_y_reg),
        .den       (den_c_reg),
        .flags     (flg_reg),
        .take      (take),
        .map_valid (map_valid),
        .map       (map),
        .map_stall (map_stall)
    );

endmodule

/* rtl/pwmg_checker.sv */
// ----------------------------------------------------------------------------
// Perspective warp map generator port checker
// Watches the item channels of the core and flags protocol or mapping slips.
// ----------------------------------------------------------------------------
`include "perspective_warp_map_generator_core_macros.svh"

module pwmg_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pix_stall,
    input logic           map_valid,
    input logic           map_stall,
    input pwmg_pkg::map_t map
);

    import pwmg_pkg::*;

    localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    logic both_at_min;

    assign both_at_min = (map.src_col == OUT_MIN) && (map.src_row == OUT_MIN);

    `PWMG_ASSERT_NXT(a_map_hold, clk, rst_n, map_valid && map_stall, map_valid && $stable(map))
    `PWMG_ASSERT_IMP(a_fault_min, clk, rst_n, map_valid && map.denom_fault, both_at_min)
    `PWMG_ASSERT_IMP(a_no_false_stall, clk, rst_n, !map_valid || !map_stall, !pix_stall)
    `PWMG_ASSERT_NXT_ANY(a_reset_empty, clk, !rst_n, !map_valid)

endmodule

bind perspective_warp_map_generator_core pwmg_checker u_pwmg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .map_valid (map_valid),
    .map_stall (map_stall),
    .map       (map)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Perspective warp map generator testbench
// Drives output pixel coordinates through the core under random idling and
// output stalls, and reprograms the eight homography coefficients between
// phases over the register port. Each accepted pixel is mapped by an
// in-bench fixed-point model, and every returned source coordinate is
// compared in order, field by field, against that prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwmg_pkg::*;

    localparam int COEF_FRAC      = COEF_FRAC_BITS_DEF;
    localparam int COEF_BITS      = COORD_BITS + COEF_FRAC;
    localparam int PIPE_LATENCY   = OUT_BITS + 6;
    localparam int IDLE_PCT       = 13;
    localparam int PHASE_ITEMS    = 230;
    localparam int STUCK_LIMIT    = 5000;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        {{(COORD_BITS-1){1'b0}}, 1'b1, {COEF_FRAC{1'b0}}};
    localparam logic signed [COEF_BITS-1:0] COEF_OUT_LSB = COEF_ONE >>> OUT_FRAC_BITS;
    localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [OUT_BITS-1:0] SRC_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam logic [OUT_BITS-1:0] SRC_MAX = ~SRC_MIN;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum int {
        COEF_REAL,
        COEF_AFFINE,
        COEF_WILD,
        COEF_ALL_MAX,
        COEF_ALL_MIN
    } coef_mode_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      pix_valid;
    logic                      pix_stall;
    pix_t                      pix;
    logic                      map_valid;
    logic                      map_stall;
    map_t                      map;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    logic signed [COEF_BITS-1:0] coef_q [NUM_REGS];
    pix_t                        pixels_to_send [$];
    map_t                        pending_src [$];
    map_t                        want;
    bit                          pix_fire;
    bit                          map_fire;
    bit                          no_idle;
    int                          bad_fields;
    int                          stuck_cycles;

    perspective_warp_map_generator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .map_valid (map_valid),
        .map_stall (map_stall),
        .map       (map),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    function automatic logic [OUT_BITS-1:0] scaled_quotient(logic signed [127:0] num,
                                                            logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        logic signed [127:0] r;
        logic signed [127:0] lim;
        logic                neg;
        lim = 128'sd1 <<< (OUT_BITS - 1);
        neg = num < 0;
        mag = neg ? -num : num;
        mag = mag <<< OUT_FRAC_BITS;
        q = mag / den;
        r = mag % den;
        if (r + r >= den)
        begin
            q = q + 1;
        end
        if (!neg)
        begin
            return (q >= lim) ? SRC_MAX : q[OUT_BITS-1:0];
        end
        if (q > lim)
        begin
            return SRC_MIN;
        end
        q = -q;
        return q[OUT_BITS-1:0];
    endfunction

    function automatic map_t inverse_map(pix_t p);
        logic signed [127:0] x;
        logic signed [127:0] y;
        logic signed [127:0] den;
        logic signed [127:0] num_col;
        logic signed [127:0] num_row;
        map_t                m;
        x = 128'(p.out_col);
        y = 128'(p.out_row);
        den = coef_q[REG_DEN_COEF_X] * x + coef_q[REG_DEN_COEF_Y] * y
            + (128'sd1 <<< COEF_FRAC);
        if (den <= 0)
        begin
            m.src_col = SRC_MIN;
            m.src_row = SRC_MIN;
            m.denom_fault = 1'b1;
            return m;
        end
        num_col = coef_q[REG_NUM_X_COEF_X] * x + coef_q[REG_NUM_X_COEF_Y] * y
                + coef_q[REG_NUM_X_CONST];
        num_row = coef_q[REG_NUM_Y_COEF_X] * x + coef_q[REG_NUM_Y_COEF_Y] * y
                + coef_q[REG_NUM_Y_CONST];
        m.src_col = scaled_quotient(num_col, den);
        m.src_row = scaled_quotient(num_row, den);
        m.denom_fault = 1'b0;
        return m;
    endfunction

    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[COEF_BITS-1:0];
    endfunction

    function automatic logic signed [COEF_BITS-1:0] coef_span(int k);
        logic signed [COEF_BITS-1:0] v;
        v = rand_coef();
        return v >>> (COEF_BITS - 1 - k);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(9))
            0, 1: return COORD_BITS'($urandom);
            2: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
            default: return COORD_BITS'(int'($urandom_range(2047)) - 1024);
        endcase
    endfunction

    task automatic queue_pixel(logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y);
        pix_t item;
        item.out_col = x;
        item.out_row = y;
        pixels_to_send.push_back(item);
    endtask

    task automatic write_coef(reg_idx_t idx, logic signed [COEF_BITS-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {REG_BYTE_SHIFT{1'b0}}};
        pwdata <= {{(APB_DATA_BITS-COEF_BITS){value[COEF_BITS-1]}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        coef_q[idx] = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_coefs(coef_mode_t mode);
        logic signed [COEF_BITS-1:0] v;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (mode)
                COEF_ALL_MAX: v = COEF_MAX;
                COEF_ALL_MIN: v = COEF_MIN;
                COEF_WILD: v = rand_coef();
                default:
                begin
                    if (i == REG_NUM_X_COEF_X || i == REG_NUM_Y_COEF_Y)
                    begin
                        v = COEF_ONE + coef_span(31);
                    end
                    else if (i == REG_NUM_X_CONST || i == REG_NUM_Y_CONST)
                    begin
                        v = coef_span(42);
                    end
                    else if (i == REG_DEN_COEF_X || i == REG_DEN_COEF_Y)
                    begin
                        v = (mode == COEF_AFFINE) ? '0 : coef_span(20);
                    end
                    else
                    begin
                        v = coef_span(31);
                    end
                end
            endcase
            write_coef(reg_idx_t'(i), v);
        end
    endtask

    task automatic drain();
        while (pixels_to_send.size() != 0 || pix_valid || pending_src.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            map_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
            if (!pix_valid || pix_fire)
            begin
                if (pixels_to_send.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    pix <= pixels_to_send.pop_front();
                    pix_valid <= 1'b1;
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pix_fire = pix_valid && !pix_stall;
            map_fire = map_valid && !map_stall;
            if (pix_fire)
            begin
                pending_src.push_back(inverse_map(pix));
            end
            if (map_fire)
            begin
                if (pending_src.size() == 0)
                begin
                    $error("map item with no pixel outstanding");
                    bad_fields++;
                end
                else
                begin
                    want = pending_src.pop_front();
                    if (map.src_col !== want.src_col)
                    begin
                        $error("src_col expected %0d got %0d",
                               $signed(want.src_col), $signed(map.src_col));
                        bad_fields++;
                    end
                    if (map.src_row !== want.src_row)
                    begin
                        $error("src_row expected %0d got %0d",
                               $signed(want.src_row), $signed(map.src_row));
                        bad_fields++;
                    end
                    if (map.denom_fault !== want.denom_fault)
                    begin
                        $error("denom_fault expected %0b got %0b",
                               want.denom_fault, map.denom_fault);
                        bad_fields++;
                    end
                end
            end
            if (pix_fire || map_fire)
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        coef_mode_t phases [8];
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix = '0;
        map_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idle = 1'b0;
        bad_fields = 0;
        stuck_cycles = 0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            coef_q[i] = '0;
        end
        coef_q[REG_NUM_X_COEF_X] = COEF_ONE;
        coef_q[REG_NUM_Y_COEF_Y] = COEF_ONE;
        phases = '{COEF_REAL, COEF_WILD, COEF_AFFINE, COEF_ALL_MAX,
                   COEF_REAL, COEF_ALL_MIN, COEF_REAL, COEF_WILD};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Identity mapping straight out of reset, coordinate extremes.
        queue_pixel(0, 0);
        queue_pixel(-1, -1);
        queue_pixel(1, 1);
        queue_pixel(COORD_MAX, COORD_MIN);
        queue_pixel(COORD_MIN, COORD_MAX);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(COORD_MIN, COORD_MIN);
        queue_pixel(16'sh5555, -16'sh5556);
        drain();

        // Denominator 1 - x: zero and negative denominators fault, x = -1 gives
        // half-pixel ties in both directions, and the extreme y weights saturate.
        write_coef(REG_NUM_X_COEF_X, '0);
        write_coef(REG_NUM_X_COEF_Y, COEF_MAX);
        write_coef(REG_NUM_X_CONST, COEF_OUT_LSB);
        write_coef(REG_NUM_Y_COEF_X, '0);
        write_coef(REG_NUM_Y_COEF_Y, COEF_MIN);
        write_coef(REG_NUM_Y_CONST, -COEF_OUT_LSB);
        write_coef(REG_DEN_COEF_X, -COEF_ONE);
        write_coef(REG_DEN_COEF_Y, '0);
        queue_pixel(-1, 0);
        queue_pixel(0, 0);
        queue_pixel(1, 0);
        queue_pixel(2, 5);
        queue_pixel(0, 1);
        queue_pixel(0, -1);
        queue_pixel(COORD_MIN, COORD_MIN);
        queue_pixel(COORD_MIN, COORD_MAX);
        queue_pixel(-3, 7);
        queue_pixel(-5, COORD_MIN);
        drain();

        foreach (phases[p])
        begin
            set_coefs(phases[p]);
            no_idle = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                queue_pixel(rand_coord(), rand_coord());
            end
            drain();
            no_idle = 1'b0;
        end

        if (bad_fields == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/pwmg_pkg.sv
rtl/pwmg_div.sv
rtl/perspective_warp_map_generator_core.sv
rtl/pwmg_checker.sv
verif/tb.sv
